// ----- src/vendor_request_fpga_loader_control_defines.svh -----
// Assertion helpers shared by the loader control block.
`ifndef VENDOR_REQUEST_FPGA_LOADER_CONTROL_DEFINES_SVH
`define VENDOR_REQUEST_FPGA_LOADER_CONTROL_DEFINES_SVH

// Same-cycle implication, sampled on clock and masked during reset.
`define VRFLC_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("loader control assertion failed");

// Next-cycle implication, sampled on clock and masked during reset.
`define VRFLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("loader control assertion failed");

`endif

// ----- src/vrflc_pkg.sv -----
package vrflc_pkg;

   localparam int PACKET_BYTES_MAX_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT      = 2;

   localparam logic [7:0] VENDOR_CODE    = 8'h10;
   localparam logic [7:0] RT_DIR_IN      = 8'h80;
   localparam logic [7:0] RT_TYPE_MASK   = 8'h60;
   localparam logic [7:0] RT_TYPE_VENDOR = 8'h40;
   localparam logic [7:0] RT_RECIP_MASK  = 8'h1f;

   localparam logic [1:0] OP_VENDOR = 2'd0;
   localparam logic [1:0] OP_PACKET = 2'd1;
   localparam logic [1:0] OP_SETCFG = 2'd2;

   localparam logic [7:0] CMD_FPGA   = 8'd0;
   localparam logic [7:0] CMD_STOP   = 8'd1;
   localparam logic [7:0] CMD_STATUS = 8'd2;
   localparam logic [7:0] CMD_PAUSE  = 8'd3;

   localparam logic [7:0] SUB_BEGIN = 8'd0;
   localparam logic [7:0] SUB_ARM   = 8'd1;
   localparam logic [7:0] SUB_END   = 8'd2;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_BEGIN     = 3'd1,
      ACT_END       = 3'd2,
      ACT_FPGA_CMD  = 3'd3,
      ACT_STATUS    = 3'd4,
      ACT_ARM       = 3'd5,
      ACT_FORWARD   = 3'd6,
      ACT_ENDPOINTS = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      HS_NONE  = 2'd0,
      HS_REARM = 2'd1,
      HS_ACK   = 2'd2,
      HS_STALL = 2'd3
   } handshake_type;

   typedef enum logic [1:0] {
      FC_RESUME = 2'd0,
      FC_STOP   = 2'd1,
      FC_PAUSE  = 2'd2
   } fpga_cmd_type;

   typedef enum logic [1:0] {
      KIND_VENDOR,
      KIND_PACKET,
      KIND_SETCFG,
      KIND_IGNORE
   } kind_type;

   // Outcome of a vendor request, decided without the state flags.
   typedef enum logic [2:0] {
      VEND_REJECT,
      VEND_BEGIN,
      VEND_END,
      VEND_ARM,
      VEND_STOP,
      VEND_PAUSE,
      VEND_RESUME,
      VEND_STATUS
   } vend_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  request_code;
      logic [7:0]  setup_attrs;
      logic [7:0]  value_low;
      logic [7:0]  value_high;
      logic [15:0] setup_length;
      logic [6:0]  packet_bytes;
      logic        fpga_error;
      logic [7:0]  fpga_status;
   } req_type;

   typedef struct packed {
      logic          accepted;
      action_type    action;
      fpga_cmd_type  fpga_command;
      logic [7:0]    status_reply;
      handshake_type handshake;
   } rsp_type;

   typedef struct packed {
      kind_type    kind;
      vend_type    vend_idle;
      vend_type    vend_load;
      logic [15:0] length;
      logic [7:0]  status;
      logic [6:0]  pkt_bytes;
      logic        pkt_over_max;
      logic        pkt_error;
      logic        cfg_ok;
      logic        cfg_on;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

// ----- src/vrflc_chan_if.sv -----
interface vrflc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- src/vrflc_front.sv -----
module vrflc_front #(
   parameter int PACKET_BYTES_MAX = vrflc_pkg::PACKET_BYTES_MAX_DEFAULT
) (
   vrflc_chan_if.sink                  req_chan,
   input  vrflc_pkg::queue_status_type q_status,
   output logic                        push,
   output vrflc_pkg::cmd_type          push_cmd
);
   import vrflc_pkg::*;

   localparam logic [6:0] MaxBytes = 7'(PACKET_BYTES_MAX);

   req_type req;
   logic    hdr_ok;
   logic    dir_in;
   logic    len_zero;

   assign req            = req_chan.payload;
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;

   assign hdr_ok   = (req.request_code == VENDOR_CODE) &&
                     ((req.setup_attrs & (RT_TYPE_MASK | RT_RECIP_MASK)) == RT_TYPE_VENDOR);
   assign dir_in   = (req.setup_attrs & RT_DIR_IN) != 8'd0;
   assign len_zero = req.setup_length == 16'd0;

   always_comb begin
      push_cmd.kind = KIND_IGNORE;
      unique case (req.op)
         OP_VENDOR: push_cmd.kind = KIND_VENDOR;
         OP_PACKET: push_cmd.kind = KIND_PACKET;
         OP_SETCFG: push_cmd.kind = KIND_SETCFG;
         default:   push_cmd.kind = KIND_IGNORE;
      endcase

      // Outcome while no bitstream load is running.
      push_cmd.vend_idle = VEND_REJECT;
      if (!dir_in) begin
         if (len_zero) begin
            unique case (req.value_high)
               CMD_FPGA: begin
                  if (req.value_low == SUB_BEGIN) push_cmd.vend_idle = VEND_BEGIN;
               end
               CMD_STOP:  push_cmd.vend_idle = VEND_STOP;
               CMD_PAUSE: push_cmd.vend_idle = (req.value_low != 8'd0) ? VEND_PAUSE
                                                                        : VEND_RESUME;
               default:   push_cmd.vend_idle = VEND_REJECT;
            endcase
         end
      end else if (req.value_high == CMD_STATUS && req.setup_length == 16'd1) begin
         push_cmd.vend_idle = VEND_STATUS;
      end

      // Outcome while a load is running: only the loader subcommands pass.
      push_cmd.vend_load = VEND_REJECT;
      if (!dir_in && req.value_high == CMD_FPGA) begin
         unique case (req.value_low)
            SUB_BEGIN: if (len_zero) push_cmd.vend_load = VEND_BEGIN;
            SUB_ARM:   if (!len_zero) push_cmd.vend_load = VEND_ARM;
            SUB_END:   if (len_zero) push_cmd.vend_load = VEND_END;
            default:   push_cmd.vend_load = VEND_REJECT;
         endcase
      end

      if (!hdr_ok) begin
         push_cmd.vend_idle = VEND_REJECT;
         push_cmd.vend_load = VEND_REJECT;
      end

      push_cmd.length       = req.setup_length;
      push_cmd.status       = req.fpga_status;
      push_cmd.pkt_bytes    = req.packet_bytes;
      push_cmd.pkt_over_max = req.packet_bytes > MaxBytes;
      push_cmd.pkt_error    = req.fpga_error;
      push_cmd.cfg_ok       = req.value_low <= 8'd1;
      push_cmd.cfg_on       = req.value_low[0];
   end
endmodule

// ----- src/vrflc_queue.sv -----
module vrflc_queue #(
   parameter int DEPTH = vrflc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  vrflc_pkg::cmd_type          push_cmd,
   input  logic                        pop,
   output vrflc_pkg::queue_status_type q_status,
   output vrflc_pkg::cmd_type          head_cmd
);
   import vrflc_pkg::*;

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastPtr  = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   cmd_type                entry_ff [DEPTH];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign q_status.valid = count_ff != '0;
   assign q_status.full  = count_ff == FullCount;
endmodule

// ----- src/vrflc_back.sv -----
`include "vendor_request_fpga_loader_control_defines.svh"

module vrflc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  vrflc_pkg::queue_status_type q_status,
   input  vrflc_pkg::cmd_type          head_cmd,
   output logic                        pop,
   vrflc_chan_if.source                rsp_chan
);
   import vrflc_pkg::*;

   logic        configured_ff, configured_in;
   logic        loading_ff, loading_in;
   logic [15:0] remaining_ff, remaining_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   vend_type    vend_sel;
   logic [15:0] pkt_wide;
   logic [15:0] diff;

   // A word leaves the queue whenever the output register is free or being drained.
   assign pop      = q_status.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign pkt_wide = {9'd0, head_cmd.pkt_bytes};
   assign diff     = remaining_ff - pkt_wide;
   assign vend_sel = !configured_ff ? VEND_REJECT
                   : (loading_ff ? head_cmd.vend_load : head_cmd.vend_idle);

   always_comb begin
      configured_in = configured_ff;
      loading_in    = loading_ff;
      remaining_in  = remaining_ff;

      rsp_in.accepted     = 1'b0;
      rsp_in.action       = ACT_NONE;
      rsp_in.fpga_command = FC_RESUME;
      rsp_in.status_reply = 8'd0;
      rsp_in.handshake    = HS_NONE;

      unique case (head_cmd.kind)
         KIND_VENDOR: begin
            rsp_in.accepted  = 1'b1;
            rsp_in.handshake = HS_ACK;
            unique case (vend_sel)
               VEND_BEGIN: begin
                  loading_in    = 1'b1;
                  rsp_in.action = ACT_BEGIN;
               end
               VEND_END: begin
                  loading_in    = 1'b0;
                  rsp_in.action = ACT_END;
               end
               VEND_ARM: begin
                  remaining_in     = head_cmd.length;
                  rsp_in.action    = ACT_ARM;
                  rsp_in.handshake = HS_REARM;
               end
               VEND_STOP: begin
                  rsp_in.action       = ACT_FPGA_CMD;
                  rsp_in.fpga_command = FC_STOP;
               end
               VEND_PAUSE: begin
                  rsp_in.action       = ACT_FPGA_CMD;
                  rsp_in.fpga_command = FC_PAUSE;
               end
               VEND_RESUME: begin
                  rsp_in.action       = ACT_FPGA_CMD;
                  rsp_in.fpga_command = FC_RESUME;
               end
               VEND_STATUS: begin
                  rsp_in.action       = ACT_STATUS;
                  rsp_in.status_reply = head_cmd.status;
               end
               default: begin
                  rsp_in.accepted  = 1'b0;
                  rsp_in.handshake = HS_STALL;
               end
            endcase
         end
         KIND_PACKET: begin
            if (remaining_ff == 16'd0) begin
               // Nothing armed: the packet is dropped silently.
               rsp_in.handshake = HS_NONE;
            end else if (pkt_wide > remaining_ff || head_cmd.pkt_over_max) begin
               remaining_in     = 16'd0;
               rsp_in.handshake = HS_STALL;
            end else if (head_cmd.pkt_error) begin
               remaining_in     = 16'd0;
               rsp_in.action    = ACT_FORWARD;
               rsp_in.handshake = HS_STALL;
            end else begin
               remaining_in     = diff;
               rsp_in.accepted  = 1'b1;
               rsp_in.action    = ACT_FORWARD;
               rsp_in.handshake = (diff != 16'd0) ? HS_REARM : HS_ACK;
            end
         end
         KIND_SETCFG: begin
            if (head_cmd.cfg_ok) begin
               configured_in    = head_cmd.cfg_on;
               rsp_in.accepted  = 1'b1;
               rsp_in.action    = ACT_ENDPOINTS;
               rsp_in.handshake = HS_ACK;
            end else begin
               rsp_in.handshake = HS_STALL;
            end
         end
         default: rsp_in.handshake = HS_NONE;
      endcase

      rsp_valid_in = pop ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         configured_ff <= 1'b0;
         loading_ff    <= 1'b0;
         remaining_ff  <= 16'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            configured_ff <= configured_in;
            loading_ff    <= loading_in;
            remaining_ff  <= remaining_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   `VRFLC_ASSERT_IMPLIES(a_accept_hs, rsp_valid_ff && rsp_ff.accepted,
      rsp_ff.handshake == HS_ACK || rsp_ff.handshake == HS_REARM)
   `VRFLC_ASSERT_IMPLIES(a_load_begin, $rose(loading_ff),
      rsp_valid_ff && rsp_ff.action == ACT_BEGIN)
   `VRFLC_ASSERT_IMPLIES(a_count_arm, remaining_ff > $past(remaining_ff),
      rsp_valid_ff && rsp_ff.action == ACT_ARM)
   `VRFLC_ASSERT_NEXT(a_setcfg, pop && head_cmd.kind == KIND_SETCFG && head_cmd.cfg_ok,
      configured_ff == $past(head_cmd.cfg_on))
endmodule

// ----- src/vendor_request_fpga_loader_control.sv -----
// Control-endpoint request decoder for the capture device's bitstream loader.
// req_chan carries one word per event: a vendor setup request, a received
// control-out data packet, or a set-configuration request. rsp_chan returns
// exactly one word per event with the verdict, the action to carry out and
// the handshake to give on the control endpoint.
// A front stage classifies each word and writes it into a short command
// queue; a back stage applies it to the configured flag, the loading flag
// and the remaining byte count, and registers the result.
// An accepted word waits in the queue until its response can be registered.
// One word is taken every cycle while the queue is not full; the back stage's
// state update and its 16-bit count subtract set that rate.
// Synchronous reset clears the flags, the byte count, the queue and the
// response valid flag; the block then reports unconfigured with nothing armed.
// When the receiver holds rsp_chan.ready low, the response register holds
// its word, the queue fills, and req_chan.ready falls once the queue is full.
module vendor_request_fpga_loader_control #(
   parameter int PACKET_BYTES_MAX = vrflc_pkg::PACKET_BYTES_MAX_DEFAULT,
   parameter int QUEUE_DEPTH      = vrflc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   vrflc_chan_if.sink   req_chan,
   vrflc_chan_if.source rsp_chan
);
   import vrflc_pkg::*;

   queue_status_type q_status;
   cmd_type          push_cmd;
   cmd_type          head_cmd;
   logic             push;
   logic             pop;

   vrflc_front #(
      .PACKET_BYTES_MAX(PACKET_BYTES_MAX)
   ) u_front (
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   vrflc_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status),
      .head_cmd (head_cmd)
   );

   vrflc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_cmd (head_cmd),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );
endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   import vrflc_pkg::*;

   localparam int         PKT_LIMIT   = PACKET_BYTES_MAX_DEFAULT;
   localparam int         ITEM_TARGET = 850;
   localparam int         CYCLE_LIMIT = 200000;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [7:0] VENDOR_OUT  = RT_TYPE_VENDOR;
   localparam logic [7:0] VENDOR_IN   = RT_DIR_IN | RT_TYPE_VENDOR;

   typedef struct {
      req_type word;
      bit      typed;
      rsp_type rsp;
   } script_row_type;

   logic        clock;
   logic        reset;

   // Shadow copy of the decoder state, advanced as each word is accepted.
   logic        cfg_on;
   logic        loading_on;
   logic [15:0] bytes_left;

   rsp_type        rsp_pending[$];
   script_row_type script[$];
   int             words_counted;
   int             req_idle_pct;
   int             rsp_stall_pct;
   int             error_count;
   int             cycle_count = 0;

   vrflc_chan_if #(.payload_type(req_type)) req_chan ();
   vrflc_chan_if #(.payload_type(rsp_type)) rsp_chan ();

   vendor_request_fpga_loader_control u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   function automatic rsp_type verdict(input logic acc, input action_type act,
                                       input fpga_cmd_type cmd, input logic [7:0] st,
                                       input handshake_type hs);
      rsp_type r;
      r.accepted     = acc;
      r.action       = act;
      r.fpga_command = cmd;
      r.status_reply = st;
      r.handshake    = hs;
      return r;
   endfunction

   function automatic rsp_type decode_event(input req_type w);
      rsp_type r;
      logic    dir_in;
      int      got;
      r = verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_STALL);
      dir_in = (w.setup_attrs & RT_DIR_IN) != 8'h00;
      got = w.packet_bytes;
      case (w.op)
         OP_VENDOR: begin
            if (cfg_on && w.request_code == VENDOR_CODE &&
                (w.setup_attrs & (RT_TYPE_MASK | RT_RECIP_MASK)) == RT_TYPE_VENDOR) begin
               if (!loading_on) begin
                  if (!dir_in && w.setup_length == 16'd0) begin
                     if (w.value_high == CMD_FPGA && w.value_low == SUB_BEGIN) begin
                        loading_on = 1'b1;
                        r = verdict(1'b1, ACT_BEGIN, FC_RESUME, 8'h00, HS_ACK);
                     end else if (w.value_high == CMD_STOP) begin
                        r = verdict(1'b1, ACT_FPGA_CMD, FC_STOP, 8'h00, HS_ACK);
                     end else if (w.value_high == CMD_PAUSE) begin
                        r = verdict(1'b1, ACT_FPGA_CMD,
                                    w.value_low != 8'h00 ? FC_PAUSE : FC_RESUME,
                                    8'h00, HS_ACK);
                     end
                  end else if (dir_in && w.value_high == CMD_STATUS &&
                               w.setup_length == 16'd1) begin
                     r = verdict(1'b1, ACT_STATUS, FC_RESUME, w.fpga_status, HS_ACK);
                  end
               end else if (!dir_in && w.value_high == CMD_FPGA) begin
                  // While loading only the three loader subcommands are honored.
                  if (w.value_low == SUB_BEGIN && w.setup_length == 16'd0) begin
                     r = verdict(1'b1, ACT_BEGIN, FC_RESUME, 8'h00, HS_ACK);
                  end else if (w.value_low == SUB_ARM && w.setup_length != 16'd0) begin
                     bytes_left = w.setup_length;
                     r = verdict(1'b1, ACT_ARM, FC_RESUME, 8'h00, HS_REARM);
                  end else if (w.value_low == SUB_END && w.setup_length == 16'd0) begin
                     loading_on = 1'b0;
                     r = verdict(1'b1, ACT_END, FC_RESUME, 8'h00, HS_ACK);
                  end
               end
            end
         end
         OP_PACKET: begin
            if (bytes_left == 16'd0) begin
               r = verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_NONE);
            end else if (got > bytes_left || got > PKT_LIMIT) begin
               bytes_left = 16'd0;
            end else if (w.fpga_error) begin
               bytes_left = 16'd0;
               r = verdict(1'b0, ACT_FORWARD, FC_RESUME, 8'h00, HS_STALL);
            end else begin
               bytes_left = bytes_left - 16'(got);
               r = verdict(1'b1, ACT_FORWARD, FC_RESUME, 8'h00,
                           bytes_left != 16'd0 ? HS_REARM : HS_ACK);
            end
         end
         OP_SETCFG: begin
            if (w.value_low <= 8'd1) begin
               cfg_on = w.value_low[0];
               r = verdict(1'b1, ACT_ENDPOINTS, FC_RESUME, 8'h00, HS_ACK);
            end
         end
         default: begin
            r = verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_NONE);
         end
      endcase
      return r;
   endfunction

   function automatic req_type mk_word(input logic [1:0] op, input logic [7:0] code,
                                       input logic [7:0] rtype, input logic [7:0] lo,
                                       input logic [7:0] hi, input logic [15:0] len,
                                       input logic [6:0] pb, input logic err,
                                       input logic [7:0] st);
      req_type w;
      w.op           = op;
      w.request_code = code;
      w.setup_attrs  = rtype;
      w.value_low    = lo;
      w.value_high   = hi;
      w.setup_length = len;
      w.packet_bytes = pb;
      w.fpga_error   = err;
      w.fpga_status  = st;
      return w;
   endfunction

   function automatic req_type noise_word();
      return mk_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 16'($urandom), 7'($urandom), 1'($urandom), 8'($urandom));
   endfunction

   function automatic req_type vendor_word(input logic dir_in, input logic [7:0] cmd,
                                           input logic [7:0] sub, input logic [15:0] len);
      req_type w;
      w = noise_word();
      w.op           = OP_VENDOR;
      w.request_code = VENDOR_CODE;
      w.setup_attrs  = dir_in ? VENDOR_IN : VENDOR_OUT;
      w.value_high   = cmd;
      w.value_low    = sub;
      w.setup_length = len;
      return w;
   endfunction

   function automatic req_type setcfg_word(input logic [7:0] cfg);
      req_type w;
      w = noise_word();
      w.op        = OP_SETCFG;
      w.value_low = cfg;
      return w;
   endfunction

   // Packet sizes are drawn against the bytes still expected, so that most
   // packets fit and some overrun or report an FPGA error.
   function automatic req_type packet_word();
      req_type w;
      int      cap;
      int      pick;
      w = noise_word();
      w.op         = OP_PACKET;
      w.fpga_error = 1'b0;
      cap  = bytes_left < PKT_LIMIT ? int'(bytes_left) : PKT_LIMIT;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         w.packet_bytes = 7'($urandom_range(0, cap));
      end else if (pick < 80) begin
         w.packet_bytes = 7'(cap);
      end else if (pick < 90) begin
         w.packet_bytes = 7'($urandom_range(cap + 1, 127));
      end else begin
         w.packet_bytes = 7'($urandom_range(0, cap));
         w.fpga_error   = 1'b1;
      end
      return w;
   endfunction

   function automatic void add_row(input req_type w, input bit typed = 1'b0,
                                   input rsp_type r = '0);
      script_row_type row;
      row.word  = w;
      row.typed = typed;
      row.rsp   = r;
      script.push_back(row);
   endfunction

   // Offers one word, waits for it to be taken and records what it should produce.
   task automatic send_word(input req_type w, input bit typed = 1'b0,
                            input rsp_type typed_rsp = '0);
      rsp_type r;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      r = decode_event(w);
      rsp_pending.push_back(typed ? typed_rsp : r);
      words_counted++;
   endtask

   task automatic loader_session();
      logic [15:0] len;
      int          sent;
      if (!cfg_on || $urandom_range(0, 7) == 0) send_word(setcfg_word(8'd1));
      send_word(vendor_word(1'b0, CMD_FPGA, SUB_BEGIN, 16'd0));
      repeat ($urandom_range(1, 3)) begin
         if ($urandom_range(0, 9) == 0) len = 16'($urandom);
         else len = 16'($urandom_range(1, 200));
         send_word(vendor_word(1'b0, CMD_FPGA, SUB_ARM, len));
         sent = 0;
         while (bytes_left != 16'd0 && sent < 12) begin
            send_word(packet_word());
            sent++;
         end
         if ($urandom_range(0, 5) == 0) send_word(noise_word());
      end
      if ($urandom_range(0, 4) != 0) send_word(vendor_word(1'b0, CMD_FPGA, SUB_END, 16'd0));
   endtask

   task automatic host_command();
      logic [7:0]  sub;
      logic [15:0] len;
      sub = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
      case ($urandom_range(0, 2))
         0:       len = 16'd0;
         1:       len = 16'd1;
         default: len = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: send_word(vendor_word(1'b1, CMD_STATUS, sub, 16'd1));
         1: send_word(vendor_word(1'b0, CMD_STOP, sub, 16'd0));
         2: send_word(vendor_word(1'b0, CMD_PAUSE, sub, 16'd0));
         3: send_word(setcfg_word(8'($urandom_range(0, 3))));
         default: begin
            send_word(vendor_word(1'($urandom), 8'($urandom_range(0, 3)),
                                  8'($urandom_range(0, 3)), len));
         end
      endcase
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      cfg_on           = 1'b0;
      loading_on       = 1'b0;
      bytes_left       = 16'd0;
      words_counted    = 0;
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      error_count      = 0;

      // Unconfigured: every vendor request stalls, stray packets and the unused op pass silently.
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_IN, 8'h00, CMD_STATUS, 16'd1, 7'd0, 1'b0,
                      8'h5a), 1'b1, verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_STALL));
      add_row(mk_word(OP_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 7'd64, 1'b0, 8'h00),
              1'b1, verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_NONE));
      add_row(mk_word(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 16'hffff, 7'h7f, 1'b1, 8'hff),
              1'b1, verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_NONE));
      add_row(mk_word(OP_SETCFG, 8'h00, 8'h00, 8'hff, 8'h00, 16'd0, 7'd0, 1'b0, 8'h00),
              1'b1, verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_STALL));
      add_row(mk_word(OP_SETCFG, 8'h00, 8'h00, 8'h01, 8'h00, 16'd0, 7'd0, 1'b0, 8'h00),
              1'b1, verdict(1'b1, ACT_ENDPOINTS, FC_RESUME, 8'h00, HS_ACK));
      // Wrong request code, wrong type and wrong recipient.
      add_row(mk_word(OP_VENDOR, 8'h11, VENDOR_OUT, 8'h00, CMD_STOP, 16'd0, 7'd0, 1'b0, 8'h00),
              1'b1, verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_STALL));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, 8'h20, 8'h00, CMD_STOP, 16'd0, 7'd0, 1'b0, 8'h00),
              1'b1, verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_STALL));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, 8'h41, 8'h00, CMD_STOP, 16'd0, 7'd0, 1'b0, 8'h00),
              1'b1, verdict(1'b0, ACT_NONE, FC_RESUME, 8'h00, HS_STALL));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_IN, 8'h00, CMD_STATUS, 16'd1, 7'd0, 1'b0,
                      8'hff), 1'b1, verdict(1'b1, ACT_STATUS, FC_RESUME, 8'hff, HS_ACK));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, 8'h00, CMD_STOP, 16'd0, 7'd0, 1'b0,
                      8'h00), 1'b1, verdict(1'b1, ACT_FPGA_CMD, FC_STOP, 8'h00, HS_ACK));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, 8'hff, CMD_PAUSE, 16'd0, 7'd0, 1'b0,
                      8'h00), 1'b1, verdict(1'b1, ACT_FPGA_CMD, FC_PAUSE, 8'h00, HS_ACK));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, 8'h00, CMD_PAUSE, 16'd0, 7'd0, 1'b0,
                      8'h00), 1'b1, verdict(1'b1, ACT_FPGA_CMD, FC_RESUME, 8'h00, HS_ACK));
      // Loader sequence: bad begin, begin, stop while loading, arm at full length.
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, SUB_BEGIN, CMD_FPGA, 16'd1, 7'd0, 1'b0,
                      8'h00));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, SUB_BEGIN, CMD_FPGA, 16'd0, 7'd0, 1'b0,
                      8'h00));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, 8'h00, CMD_STOP, 16'd0, 7'd0, 1'b0,
                      8'h00));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, SUB_ARM, CMD_FPGA, 16'hffff, 7'd0,
                      1'b0, 8'h00));
      add_row(mk_word(OP_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 7'd64, 1'b0, 8'h00));
      // A packet above the largest size stalls and clears the count.
      add_row(mk_word(OP_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 7'h7f, 1'b0, 8'h00));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, SUB_ARM, CMD_FPGA, 16'd100, 7'd0,
                      1'b0, 8'h00));
      add_row(mk_word(OP_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 7'd64, 1'b1, 8'h00));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, SUB_ARM, CMD_FPGA, 16'd3, 7'd0, 1'b0,
                      8'h00));
      add_row(mk_word(OP_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 7'd5, 1'b0, 8'h00));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, SUB_ARM, CMD_FPGA, 16'd3, 7'd0, 1'b0,
                      8'h00));
      add_row(mk_word(OP_PACKET, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 7'd3, 1'b0, 8'h00));
      add_row(mk_word(OP_VENDOR, VENDOR_CODE, VENDOR_OUT, SUB_END, CMD_FPGA, 16'd0, 7'd0, 1'b0,
                      8'h00));
      add_row(mk_word(OP_SETCFG, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0, 7'd0, 1'b0, 8'h00),
              1'b1, verdict(1'b1, ACT_ENDPOINTS, FC_RESUME, 8'h00, HS_ACK));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) send_word(script[i].word, script[i].typed, script[i].rsp);

      // Four random phases: no idling, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         req_idle_pct  = (phase == 1) ? 74 : (phase == 3) ? 34 : 0;
         rsp_stall_pct = (phase == 2) ? 74 : (phase == 3) ? 34 : 0;
         words_counted = 0;
         while (words_counted < ITEM_TARGET / 4) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: loader_session();
               6, 7:             host_command();
               default:          send_word(noise_word());
            endcase
         end
      end
      req_chan.valid <= 1'b0;

      while (rsp_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && rsp_pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (rsp_pending.size() == 0) begin
               error_count++;
               $display("%0t: response word with nothing expected, got %h", $time,
                        rsp_chan.payload);
            end else begin
               want = rsp_pending.pop_front();
               if (rsp_chan.payload.accepted !== want.accepted ||
                   rsp_chan.payload.action !== want.action ||
                   rsp_chan.payload.fpga_command !== want.fpga_command ||
                   rsp_chan.payload.status_reply !== want.status_reply ||
                   rsp_chan.payload.handshake !== want.handshake) begin
                  error_count++;
                  $display("%0t: mismatch, expected acc %0d act %0d cmd %0d status %h hs %0d;",
                           $time, want.accepted, want.action, want.fpga_command,
                           want.status_reply, want.handshake,
                           " got acc %0d act %0d cmd %0d status %h hs %0d",
                           rsp_chan.payload.accepted, rsp_chan.payload.action,
                           rsp_chan.payload.fpga_command, rsp_chan.payload.status_reply,
                           rsp_chan.payload.handshake);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end
endmodule
